### sv/sqc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqc_pkg
// Shared types, event codes and lookup tables for the square-wave channel.
// ----------------------------------------------------------------------------
package sqc_pkg;

  typedef enum logic [2:0] {
    MODE_REG_WRITE = 3'd0,
    MODE_TIMER     = 3'd1,
    MODE_QUARTER   = 3'd2,
    MODE_HALF      = 3'd3,
    MODE_ENABLE    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    REG_DUTY_ENV  = 2'd0,
    REG_SWEEP     = 2'd1,
    REG_PERIOD_LO = 2'd2,
    REG_PERIOD_HI = 2'd3
  } reg_e;

  localparam int PeriodW = 11;
  localparam logic [PeriodW:0]   PeriodMax  = 12'h7FF;
  localparam logic [PeriodW-1:0] PeriodLow8 = 11'd8;
  localparam logic [3:0]         EnvTop     = 4'd15;

  // bit n = output at sequencer position n
  localparam logic [7:0] DutyBits [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:  val = 8'd10;   5'd1:  val = 8'd254;  5'd2:  val = 8'd20;  5'd3:  val = 8'd2;
      5'd4:  val = 8'd40;   5'd5:  val = 8'd4;    5'd6:  val = 8'd80;  5'd7:  val = 8'd6;
      5'd8:  val = 8'd160;  5'd9:  val = 8'd8;    5'd10: val = 8'd60;  5'd11: val = 8'd10;
      5'd12: val = 8'd14;   5'd13: val = 8'd12;   5'd14: val = 8'd26;  5'd15: val = 8'd14;
      5'd16: val = 8'd12;   5'd17: val = 8'd16;   5'd18: val = 8'd24;  5'd19: val = 8'd18;
      5'd20: val = 8'd48;   5'd21: val = 8'd20;   5'd22: val = 8'd96;  5'd23: val = 8'd22;
      5'd24: val = 8'd192;  5'd25: val = 8'd24;   5'd26: val = 8'd72;  5'd27: val = 8'd26;
      5'd28: val = 8'd16;   5'd29: val = 8'd28;   5'd30: val = 8'd32;  5'd31: val = 8'd30;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

  // Sweep target period, 12 bits so overflow past 0x7FF is visible.
  function automatic logic [PeriodW:0] sweep_target(input logic [PeriodW-1:0] period,
                                                     input logic [2:0]         shift,
                                                     input logic               negate,
                                                     input logic               ones_comp);
    logic [PeriodW-1:0] change;
    logic [PeriodW:0]   sub;
    logic [PeriodW:0]   res;
    change = period >> shift;
    sub    = {1'b0, change} + {{PeriodW{1'b0}}, ones_comp};
    if (!negate) begin
      res = {1'b0, period} + {1'b0, change};
    end else if ({1'b0, period} >= sub) begin
      res = {1'b0, period} - sub;
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### sv/sqc_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqc_intf
// Valid/ready channels of the square-wave channel: events, results, config.
// ----------------------------------------------------------------------------
interface sqc_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [1:0] reg_index;
  logic [7:0] data;
  logic       enable_value;

  modport source (output valid, mode, reg_index, data, enable_value, input ready);
  modport sink   (input valid, mode, reg_index, data, enable_value, output ready);
endinterface

interface sqc_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] level;
  logic       length_active;
  logic       sweep_changed;

  modport source (output valid, level, length_active, sweep_changed, input ready);
  modport sink   (input valid, level, length_active, sweep_changed, output ready);
endinterface

interface sqc_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### sv/square_wave_sound_channel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_wave_sound_channel
// Pulse channel: duty sequencer, envelope, sweep and length counter.
// ----------------------------------------------------------------------------
// Takes one event item per clock unless the result slot stalls; one result
// item per event comes next cycle. All channel state updates in the accepting
// cycle; the result (level, length flag) is decoded from the updated state
// registers and the sweep-changed flag is held in the result register, so an
// event can be accepted whenever the result slot is empty or being drained.
// The sweep adder/compare on the period register sets the cycle time. The
// config register (ones-complement negate, reset 1) is always ready.
module square_wave_sound_channel (
  input  wire        clk_i,
  input  wire        rst_ni,
  sqc_cfg_if.sink    cfg_i,
  sqc_evt_if.sink    evt_i,
  sqc_res_if.source  res_o
);

  localparam int PW = sqc_pkg::PeriodW;

  logic          ones_q;
  logic [1:0]    duty_sel_q, duty_sel_d;
  logic          halt_q, halt_d;
  logic          const_vol_q, const_vol_d;
  logic [3:0]    vol_q, vol_d;
  logic          env_start_q, env_start_d;
  logic [3:0]    env_decay_q, env_decay_d;
  logic [3:0]    env_div_q, env_div_d;
  logic          sw_en_q, sw_en_d;
  logic [2:0]    sw_period_q, sw_period_d;
  logic          sw_neg_q, sw_neg_d;
  logic [2:0]    sw_shift_q, sw_shift_d;
  logic          sw_reload_q, sw_reload_d;
  logic [2:0]    sw_div_q, sw_div_d;
  logic [PW-1:0] period_q, period_d;
  logic [PW-1:0] count_q, count_d;
  logic [2:0]    step_q, step_d;
  logic [7:0]    length_q, length_d;
  logic          on_q, on_d;
  logic          changed_q, changed_d;
  logic          res_valid_q;

  logic          evt_fire;
  logic [PW:0]   target_cur;
  logic          mute_cur;
  logic [PW-1:0] period_hi_wr;

  assign evt_fire    = evt_i.valid && evt_i.ready;
  assign evt_i.ready = !res_valid_q || res_o.ready;
  assign cfg_i.ready = 1'b1;

  assign target_cur = sqc_pkg::sweep_target(period_q, sw_shift_q, sw_neg_q, ones_q);
  assign mute_cur   = (period_q < sqc_pkg::PeriodLow8) || (target_cur > sqc_pkg::PeriodMax);
  assign period_hi_wr = {evt_i.data[2:0], period_q[7:0]};

  always_comb begin
    duty_sel_d  = duty_sel_q;
    halt_d      = halt_q;
    const_vol_d = const_vol_q;
    vol_d       = vol_q;
    env_start_d = env_start_q;
    env_decay_d = env_decay_q;
    env_div_d   = env_div_q;
    sw_en_d     = sw_en_q;
    sw_period_d = sw_period_q;
    sw_neg_d    = sw_neg_q;
    sw_shift_d  = sw_shift_q;
    sw_reload_d = sw_reload_q;
    sw_div_d    = sw_div_q;
    period_d    = period_q;
    count_d     = count_q;
    step_d      = step_q;
    length_d    = length_q;
    on_d        = on_q;
    changed_d   = 1'b0;
    case (evt_i.mode)
      sqc_pkg::MODE_REG_WRITE: begin
        case (evt_i.reg_index)
          sqc_pkg::REG_DUTY_ENV: begin
            duty_sel_d  = evt_i.data[7:6];
            halt_d      = evt_i.data[5];
            const_vol_d = evt_i.data[4];
            vol_d       = evt_i.data[3:0];
          end
          sqc_pkg::REG_SWEEP: begin
            sw_en_d     = evt_i.data[7];
            sw_period_d = evt_i.data[6:4];
            sw_neg_d    = evt_i.data[3];
            sw_shift_d  = evt_i.data[2:0];
            sw_reload_d = 1'b1;
          end
          sqc_pkg::REG_PERIOD_LO: begin
            period_d = {period_q[PW-1:8], evt_i.data};
          end
          sqc_pkg::REG_PERIOD_HI: begin
            period_d = period_hi_wr;
            if (on_q) begin
              length_d = sqc_pkg::length_lookup(evt_i.data[7:3]);
            end
            step_d      = 3'd0;
            count_d     = period_hi_wr;
            env_start_d = 1'b1;
          end
          default: begin
          end
        endcase
      end
      sqc_pkg::MODE_TIMER: begin
        if (count_q == '0) begin
          step_d  = step_q + 3'd1;
          count_d = period_q;
        end else begin
          count_d = count_q - PW'(1);
        end
      end
      sqc_pkg::MODE_QUARTER: begin
        if (env_start_q) begin
          env_start_d = 1'b0;
          env_decay_d = sqc_pkg::EnvTop;
          env_div_d   = vol_q;
        end else if (env_div_q != 4'd0) begin
          env_div_d = env_div_q - 4'd1;
        end else begin
          env_div_d = vol_q;
          if (env_decay_q != 4'd0) begin
            env_decay_d = env_decay_q - 4'd1;
          end else if (halt_q) begin
            env_decay_d = sqc_pkg::EnvTop;
          end
        end
      end
      sqc_pkg::MODE_HALF: begin
        if (length_q != 8'd0 && !halt_q) begin
          length_d = length_q - 8'd1;
        end
        if (sw_div_q == 3'd0 || sw_reload_q) begin
          if (sw_div_q == 3'd0 && sw_en_q && sw_shift_q != 3'd0 && !mute_cur) begin
            period_d  = target_cur[PW-1:0];
            changed_d = 1'b1;
          end
          sw_div_d    = sw_period_q;
          sw_reload_d = 1'b0;
        end else begin
          sw_div_d = sw_div_q - 3'd1;
        end
      end
      sqc_pkg::MODE_ENABLE: begin
        on_d = evt_i.enable_value;
        if (!evt_i.enable_value) begin
          length_d = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ones_q      <= 1'b1;
      duty_sel_q  <= '0;
      halt_q      <= 1'b0;
      const_vol_q <= 1'b0;
      vol_q       <= '0;
      env_start_q <= 1'b0;
      env_decay_q <= '0;
      env_div_q   <= '0;
      sw_en_q     <= 1'b0;
      sw_period_q <= '0;
      sw_neg_q    <= 1'b0;
      sw_shift_q  <= '0;
      sw_reload_q <= 1'b0;
      sw_div_q    <= '0;
      period_q    <= '0;
      count_q     <= '0;
      step_q      <= '0;
      length_q    <= '0;
      on_q        <= 1'b0;
      changed_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        ones_q <= cfg_i.data;
      end
      if (evt_fire) begin
        duty_sel_q  <= duty_sel_d;
        halt_q      <= halt_d;
        const_vol_q <= const_vol_d;
        vol_q       <= vol_d;
        env_start_q <= env_start_d;
        env_decay_q <= env_decay_d;
        env_div_q   <= env_div_d;
        sw_en_q     <= sw_en_d;
        sw_period_q <= sw_period_d;
        sw_neg_q    <= sw_neg_d;
        sw_shift_q  <= sw_shift_d;
        sw_reload_q <= sw_reload_d;
        sw_div_q    <= sw_div_d;
        period_q    <= period_d;
        count_q     <= count_d;
        step_q      <= step_d;
        length_q    <= length_d;
        on_q        <= on_d;
        changed_q   <= changed_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result decoded from the state left by the last accepted item.
  logic duty_hi;
  logic [3:0] level;

  assign duty_hi = sqc_pkg::DutyBits[duty_sel_q][step_q];

  always_comb begin
    if (!on_q || length_q == 8'd0 || mute_cur || !duty_hi) begin
      level = 4'd0;
    end else if (const_vol_q) begin
      level = vol_q;
    end else begin
      level = env_decay_q;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.level         = level;
  assign res_o.length_active = (length_q != 8'd0);
  assign res_o.sweep_changed = changed_q;

  // Only a half-frame clock may report a period rewrite.
  a_changed_half_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_fire && evt_i.mode != sqc_pkg::MODE_HALF |=> !changed_q)
    else $error("sweep_changed set by a non half-frame item");

  // Disabling the channel clears the length counter.
  a_disable_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_fire && evt_i.mode == sqc_pkg::MODE_ENABLE && !evt_i.enable_value
    |=> !res_o.length_active && res_o.level == 4'd0)
    else $error("channel disable left length active");

  // A high-period write restarts the sequencer and arms the envelope.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_fire && evt_i.mode == sqc_pkg::MODE_REG_WRITE &&
    evt_i.reg_index == sqc_pkg::REG_PERIOD_HI |=> step_q == 3'd0 && env_start_q)
    else $error("period high write did not restart channel");

  // A nonzero level needs an enabled, unmuted channel with length left.
  a_level_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.level != 4'd0 |-> on_q && length_q != 8'd0 && !mute_cur)
    else $error("level nonzero on a silenced channel");

  // A stalled result is not overwritten.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.ready |-> !evt_i.ready)
    else $error("event accepted while result stalled");

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the square-wave channel: a clocked driver offers
// event items from a queue, a shadow channel model predicts each result, and
// a clocked monitor compares every result item field by field. Both sides
// idle at random; the sweep negate mode is switched between phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 125;

  localparam logic [7:0] LengthLoad [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };
  localparam logic [7:0] DutyPattern [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

  typedef struct packed {
    logic [1:0]  duty_sel;
    logic        halt_loop;
    logic        const_vol;
    logic [3:0]  vol_env;
    logic        env_start;
    logic [3:0]  env_decay;
    logic [3:0]  env_div;
    logic        sw_en;
    logic [2:0]  sw_period;
    logic        sw_neg;
    logic [2:0]  sw_shift;
    logic        sw_reload;
    logic [2:0]  sw_div;
    logic [10:0] period;
    logic [10:0] period_cnt;
    logic [2:0]  duty_pos;
    logic [7:0]  length;
    logic        chan_on;
  } chan_state_t;

  typedef struct packed {
    logic [3:0] level;
    logic       length_active;
    logic       sweep_changed;
  } chan_result_t;

  typedef struct {
    logic [2:0] mode;
    logic [1:0] reg_index;
    logic [7:0] data;
    logic       enable_value;
    int         gap;
    bit         sync;
  } event_item_t;

  logic clk;
  logic rst_ni;

  sqc_cfg_if cfg_bus ();
  sqc_evt_if evt_bus ();
  sqc_res_if res_bus ();

  square_wave_sound_channel dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .evt_i  (evt_bus),
    .res_o  (res_bus)
  );

  chan_state_t  ch = '0;
  logic         ones_comp = 1'b1;
  event_item_t  pending_events [$];
  event_item_t  cur_event;
  chan_result_t expected_results [$];

  int  items_pushed = 0;
  int  live_pushed = 0;
  int  items_accepted = 0;
  int  results_checked = 0;
  int  fail_count = 0;
  int  cfg_writes = 0;
  int  reg_writes = 0;
  int  sweep_rewrites = 0;
  int  audible_levels = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  logic rx_hold;
  bit  pause_next = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow channel model
  // --------------------------------------------------------------------------
  function automatic logic [11:0] sweep_goal();
    logic [10:0] change;
    logic [11:0] sub;
    change = ch.period >> ch.sw_shift;
    if (!ch.sw_neg) return {1'b0, ch.period} + {1'b0, change};
    sub = {1'b0, change} + {11'd0, ones_comp};
    return ({1'b0, ch.period} >= sub) ? ({1'b0, ch.period} - sub) : 12'd0;
  endfunction

  function automatic bit sweep_muted();
    return (ch.period < 11'd8) || (sweep_goal() > 12'h7FF);
  endfunction

  function automatic chan_result_t step_channel(input event_item_t ev);
    chan_result_t r;
    logic [11:0]  goal;
    r = '0;
    case (ev.mode)
      sqc_pkg::MODE_REG_WRITE: begin
        reg_writes++;
        case (ev.reg_index)
          sqc_pkg::REG_DUTY_ENV: begin
            ch.duty_sel  = ev.data[7:6];
            ch.halt_loop = ev.data[5];
            ch.const_vol = ev.data[4];
            ch.vol_env   = ev.data[3:0];
          end
          sqc_pkg::REG_SWEEP: begin
            ch.sw_en     = ev.data[7];
            ch.sw_period = ev.data[6:4];
            ch.sw_neg    = ev.data[3];
            ch.sw_shift  = ev.data[2:0];
            ch.sw_reload = 1'b1;
          end
          sqc_pkg::REG_PERIOD_LO: ch.period[7:0] = ev.data;
          default: begin
            ch.period[10:8] = ev.data[2:0];
            // length only loads while the channel is enabled
            if (ch.chan_on) ch.length = LengthLoad[ev.data[7:3]];
            ch.duty_pos   = 3'd0;
            ch.period_cnt = ch.period;
            ch.env_start  = 1'b1;
          end
        endcase
      end
      sqc_pkg::MODE_TIMER: begin
        if (ch.period_cnt == 11'd0) begin
          ch.duty_pos   = ch.duty_pos + 3'd1;
          ch.period_cnt = ch.period;
        end else begin
          ch.period_cnt = ch.period_cnt - 11'd1;
        end
      end
      sqc_pkg::MODE_QUARTER: begin
        if (ch.env_start) begin
          ch.env_start = 1'b0;
          ch.env_decay = 4'd15;
          ch.env_div   = ch.vol_env;
        end else if (ch.env_div != 4'd0) begin
          ch.env_div = ch.env_div - 4'd1;
        end else begin
          ch.env_div = ch.vol_env;
          if (ch.env_decay != 4'd0) ch.env_decay = ch.env_decay - 4'd1;
          else if (ch.halt_loop) ch.env_decay = 4'd15;
        end
      end
      sqc_pkg::MODE_HALF: begin
        if (ch.length != 8'd0 && !ch.halt_loop) ch.length = ch.length - 8'd1;
        if (ch.sw_div == 3'd0 || ch.sw_reload) begin
          if (ch.sw_div == 3'd0 && ch.sw_en && ch.sw_shift != 3'd0 && !sweep_muted()) begin
            goal = sweep_goal();
            ch.period = goal[10:0];
            r.sweep_changed = 1'b1;
            sweep_rewrites++;
          end
          ch.sw_div    = ch.sw_period;
          ch.sw_reload = 1'b0;
        end else begin
          ch.sw_div = ch.sw_div - 3'd1;
        end
      end
      sqc_pkg::MODE_ENABLE: begin
        ch.chan_on = ev.enable_value;
        if (!ev.enable_value) ch.length = 8'd0;
      end
      default: ;
    endcase
    r.length_active = (ch.length != 8'd0);
    if (!ch.chan_on || ch.length == 8'd0 || sweep_muted() ||
        !DutyPattern[ch.duty_sel][ch.duty_pos]) begin
      r.level = 4'd0;
    end else begin
      r.level = ch.const_vol ? ch.vol_env : ch.env_decay;
    end
    if (r.level != 4'd0) audible_levels++;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Event driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_events
    bit           took;
    chan_result_t predicted;
    if (!rst_ni) begin
      evt_bus.valid        <= 1'b0;
      evt_bus.mode         <= sqc_pkg::MODE_REG_WRITE;
      evt_bus.reg_index    <= sqc_pkg::REG_DUTY_ENV;
      evt_bus.data         <= 8'd0;
      evt_bus.enable_value <= 1'b0;
      tx_wait              <= 0;
    end else if (!(evt_bus.valid && !evt_bus.ready)) begin
      took = evt_bus.valid;
      if (took) begin
        predicted = step_channel(cur_event);
        expected_results.insert(expected_results.size(), predicted);
        items_accepted <= items_accepted + 1;
      end
      if (tx_wait > 0) begin
        evt_bus.valid <= 1'b0;
        tx_wait       <= tx_wait - 1;
      end else if (pending_events.size() != 0 &&
                   (!pending_events[0].sync || items_accepted + took == results_checked)) begin
        cur_event = pending_events[0];
        pending_events.delete(0);
        evt_bus.valid        <= 1'b1;
        evt_bus.mode         <= cur_event.mode;
        evt_bus.reg_index    <= cur_event.reg_index;
        evt_bus.data         <= cur_event.data;
        evt_bus.enable_value <= cur_event.enable_value;
        tx_wait              <= cur_event.gap;
      end else begin
        evt_bus.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  function automatic int rx_stall();
    // a calm window every hundred items
    return ((items_accepted % 100) < 20) ? 0 : $urandom_range(0, 17);
  endfunction

  always @(posedge clk) begin : check_results
    chan_result_t want;
    int           stall;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      rx_wait       <= 0;
    end else if (res_bus.valid && res_bus.ready) begin
      results_checked <= results_checked + 1;
      if (expected_results.size() == 0) begin
        $error("result item arrived with nothing expected");
        fail_count++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (res_bus.level !== want.level) begin
          $error("level mismatch: expected %0d, actual %0d", want.level, res_bus.level);
          fail_count++;
        end
        if (res_bus.length_active !== want.length_active) begin
          $error("length_active mismatch: expected %0d, actual %0d",
                 want.length_active, res_bus.length_active);
          fail_count++;
        end
        if (res_bus.sweep_changed !== want.sweep_changed) begin
          $error("sweep_changed mismatch: expected %0d, actual %0d",
                 want.sweep_changed, res_bus.sweep_changed);
          fail_count++;
        end
      end
      stall = rx_stall();
      rx_wait       <= stall;
      res_bus.ready <= (stall == 0) && !rx_hold;
    end else if (rx_wait > 0) begin
      rx_wait       <= rx_wait - 1;
      res_bus.ready <= (rx_wait == 1) && !rx_hold;
    end else begin
      res_bus.ready <= !rx_hold;
    end
  end

  // long receiver hold-off mid-run so the channel backs up and stalls its input
  initial begin : long_receiver_hold
    rx_hold = 1'b0;
    wait (items_accepted >= 220);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (!rst_ni || (evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_event(input logic [2:0] mode, input logic [1:0] reg_index,
                                      input logic [7:0] data, input logic enable_value);
    event_item_t it;
    it.mode         = mode;
    it.reg_index    = reg_index;
    it.data         = data;
    it.enable_value = enable_value;
    it.gap          = ((items_pushed % 100) inside {[70:89]}) ? 0 : $urandom_range(0, 17);
    it.sync         = pause_next;
    pause_next      = 1'b0;
    pending_events.insert(pending_events.size(), it);
    items_pushed++;
    if (mode <= sqc_pkg::MODE_ENABLE) live_pushed++;
  endfunction

  // well-formed note start: enable, then the four channel registers in order
  function automatic void queue_note();
    queue_event(sqc_pkg::MODE_ENABLE, 2'($urandom), 8'($urandom), 1'b1);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_DUTY_ENV, 8'($urandom), 1'($urandom));
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_SWEEP, 8'($urandom), 1'($urandom));
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_PERIOD_LO, 8'($urandom_range(8, 60)),
                1'($urandom));
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_PERIOD_HI, {5'($urandom), 3'b000},
                1'($urandom));
  endfunction

  function automatic void queue_random_event();
    int         pick;
    logic [1:0] r;
    logic [7:0] d;
    logic       en;
    pick = $urandom_range(0, 99);
    r    = 2'($urandom);
    d    = 8'($urandom);
    en   = 1'($urandom);
    if (pick < 25) begin
      // keep periods short most of the time so the sequencer actually steps
      if (r == sqc_pkg::REG_PERIOD_LO && $urandom_range(0, 1) == 1) d = 8'($urandom_range(8, 40));
      if (r == sqc_pkg::REG_PERIOD_HI && $urandom_range(0, 3) != 0) d[2:0] = 3'b000;
      queue_event(sqc_pkg::MODE_REG_WRITE, r, d, en);
    end else if (pick < 60) begin
      queue_event(sqc_pkg::MODE_TIMER, r, d, en);
    end else if (pick < 72) begin
      queue_event(sqc_pkg::MODE_QUARTER, r, d, en);
    end else if (pick < 84) begin
      queue_event(sqc_pkg::MODE_HALF, r, d, en);
    end else if (pick < 93) begin
      queue_event(sqc_pkg::MODE_ENABLE, r, d, ($urandom_range(0, 4) != 0));
    end else begin
      queue_event(3'($urandom_range(5, 7)), r, d, en);
    end
  endfunction

  task automatic run_random_phase(input int n_live);
    int start;
    bit paused;
    start  = live_pushed;
    paused = 1'b0;
    while (live_pushed - start < n_live) begin
      if (!paused && live_pushed - start >= n_live / 2) begin
        pause_next = 1'b1;
        paused     = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) queue_note();
      else queue_random_event();
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (items_accepted != items_pushed || results_checked != items_accepted);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_negate_mode(input logic ones);
    cfg_bus.data  <= ones;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    ones_comp = ones;
    cfg_writes++;
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = 1'b0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // disabled channel: enable clear, then a period-high write that skips the length load
    queue_event(sqc_pkg::MODE_ENABLE, 2'd0, 8'h00, 1'b0);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_PERIOD_HI, 8'hF8, 1'b0);
    // unknown modes leave the state alone
    queue_event(3'd5, 2'd3, 8'hFF, 1'b1);
    queue_event(3'd7, 2'd0, 8'h00, 1'b0);
    queue_event(sqc_pkg::MODE_ENABLE, 2'd3, 8'hFF, 1'b1);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_DUTY_ENV, 8'hFF, 1'b1);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_SWEEP, 8'h89, 1'b0);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_PERIOD_LO, 8'h00, 1'b0);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_PERIOD_HI, 8'h08, 1'b0);
    // period zero: negated target clamps to zero, muted so no rewrite
    queue_event(sqc_pkg::MODE_HALF, 2'd0, 8'h00, 1'b0);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_PERIOD_LO, 8'hFF, 1'b0);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_PERIOD_HI, 8'h07, 1'b0);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_SWEEP, 8'h81, 1'b0);
    // target past the top: muted, period kept
    queue_event(sqc_pkg::MODE_HALF, 2'd1, 8'hFF, 1'b1);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_PERIOD_LO, 8'h10, 1'b0);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_PERIOD_HI, 8'h00, 1'b0);
    queue_event(sqc_pkg::MODE_HALF, 2'd2, 8'h00, 1'b0);
    queue_event(sqc_pkg::MODE_REG_WRITE, sqc_pkg::REG_DUTY_ENV, 8'h00, 1'b0);
    queue_event(sqc_pkg::MODE_QUARTER, 2'd0, 8'h00, 1'b0);
    queue_event(sqc_pkg::MODE_QUARTER, 2'd3, 8'hFF, 1'b1);
    queue_event(sqc_pkg::MODE_TIMER, 2'd0, 8'h00, 1'b0);
    queue_event(sqc_pkg::MODE_TIMER, 2'd1, 8'h55, 1'b1);
    queue_event(sqc_pkg::MODE_TIMER, 2'd2, 8'hAA, 1'b0);
    queue_event(sqc_pkg::MODE_ENABLE, 2'd0, 8'h00, 1'b0);
    queue_event(3'd6, 2'd1, 8'h5A, 1'b1);
    wait_idle();

    set_negate_mode(1'b0);
    run_random_phase(PhaseItems);
    wait_idle();

    set_negate_mode(1'b1);
    run_random_phase(PhaseItems);
    wait_idle();

    set_negate_mode(1'b0);
    run_random_phase(PhaseItems);
    wait_idle();

    $display("Checked %0d results for %0d event items: %0d register writes, %0d sweep rewrites,",
             results_checked, items_accepted, reg_writes, sweep_rewrites);
    $display("%0d audible levels; negate mode written %0d times, one long receiver hold-off.",
             audible_levels, cfg_writes);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
